FILE: hw/rtl/rrbf_pkg.sv
// -----------------------------------------------------------------------------
// rrbf_pkg: shared types and constants for the randomized-response bit flipper
// Word formats, register indexes, Mersenne Twister constants and tempering.
// -----------------------------------------------------------------------------
package rrbf_pkg;

    // Largest matrix side supported
    localparam int MAX_NODES = 1024;
    localparam int POS_W     = $clog2(MAX_NODES);
    localparam int SIDE_W    = $clog2(MAX_NODES + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_SEED    = 2'd2;

    localparam logic [10:0] NODE_COUNT_RST     = 11'd2;
    localparam logic [31:0] KEEP_THRESHOLD_RST = 32'd2147483647;
    localparam logic [31:0] MASTER_SEED_RST    = 32'd5489;

    // MT19937
    localparam int MT_N     = 624;
    localparam int MT_M     = 397;
    localparam int MT_IDX_W = $clog2(MT_N);
    localparam logic [31:0] MT_MATRIX = 32'h9908b0df;
    localparam logic [31:0] MT_UPPER  = 32'h80000000;
    localparam logic [31:0] MT_LOWER  = 32'h7fffffff;
    localparam logic [31:0] MT_MUL    = 32'd1812433253;

    typedef struct packed {
        logic cell_bit;
        logic row_exempt;
    } in_word_t;

    typedef struct packed {
        logic noisy_bit;
        logic was_flipped;
        logic matrix_end;
    } out_word_t;

    // Output tempering
    function automatic logic [31:0] mt_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Twist combine: new = c ^ (y >> 1) ^ (odd ? matrix : 0)
    function automatic logic [31:0] mt_mix(input logic [31:0] hi, input logic [31:0] lo,
                                           input logic [31:0] c);
        logic [31:0] y;
        y = (hi & MT_UPPER) | (lo & MT_LOWER);
        return c ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    endfunction

endpackage

FILE: hw/rtl/randomized_response_bit_flip.sv
// An ineligible cell (diagonal or exempt row) gives its word in the cycle after acceptance;
//   an eligible cell takes longer, set by the 397 reseed steps through the one
//   shared multiplier plus the three reads of the master table through its single read port.
// Throughput: one cell at a time; the next is taken once the current word is finished.
// Reset, end of matrix and a node_count or master_seed write start a reload of all 624 words of the
//   master table, during which no cell is accepted.
// -----------------------------------------------------------------------------
// randomized_response_bit_flip: randomized-response noise on an adjacency matrix
// Per eligible cell a master MT19937 word reseeds a second generator whose
// first output decides whether the cell is inverted.
// -----------------------------------------------------------------------------
module randomized_response_bit_flip (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  rrbf_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output rrbf_pkg::out_word_t               out_data,
    input  logic                              cfg_we,
    input  logic [rrbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrbf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rrbf_pkg::*;

    typedef enum logic [3:0] {
        S_SEED, S_INIT, S_IDLE, S_RD0, S_RD1, S_RD2, S_TW, S_FD0, S_FD, S_DRAW, S_DONE
    } state_t;

    state_t              state_reg;
    logic [10:0]         node_count_reg;
    logic [31:0]         keep_threshold_reg;
    logic [31:0]         master_seed_reg;
    logic [POS_W-1:0]    row_reg, col_reg;
    logic [MT_IDX_W-1:0] ptr_reg, idx_reg;
    logic [31:0]         prod_reg, a_reg, b_reg, seed_reg, e1_reg, v_last_reg;
    logic                bit_reg, last_reg, flip_reg;
    logic                out_valid_reg;
    out_word_t           out_reg;

    // Master table
    logic [31:0]         mem [MT_N];
    logic [31:0]         rdata_reg;
    logic                mem_we;
    logic [MT_IDX_W-1:0] mem_wa, mem_ra;
    logic [31:0]         mem_wd;

    logic [SIDE_W-1:0]   side;
    logic                in_acc, out_free, eligible, last_cell;
    logic [31:0]         v_sum, mul_in, mul_out, twist_word, draw;
    logic [MT_IDX_W-1:0] ptr_p1, ptr_pm;

    // Side length, clamped to the supported range
    always_comb
    begin
        if (32'(node_count_reg) < 32'd2)
            side = SIDE_W'(2);
        else if (32'(node_count_reg) > 32'(MAX_NODES))
            side = SIDE_W'(MAX_NODES);
        else
            side = SIDE_W'(node_count_reg);
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign eligible  = !in_data.row_exempt && (row_reg != col_reg);
    assign last_cell = (SIDE_W'(row_reg) == side - SIDE_W'(1)) &&
                       (SIDE_W'(col_reg) == side - SIDE_W'(1));

    // Shared init-step unit: v = prod + i, then MUL * (v ^ v >> 30)
    assign v_sum = prod_reg + 32'(idx_reg);
    always_comb
    begin
        unique case (state_reg)
            S_SEED:  mul_in = master_seed_reg;
            S_FD0:   mul_in = seed_reg;
            default: mul_in = v_sum;
        endcase
    end
    assign mul_out = MT_MUL * (mul_in ^ (mul_in >> 30));

    // Table addressing with wrap
    assign ptr_p1 = (ptr_reg == MT_IDX_W'(MT_N - 1)) ? '0 : ptr_reg + MT_IDX_W'(1);
    assign ptr_pm = (ptr_reg >= MT_IDX_W'(MT_N - MT_M)) ? ptr_reg - MT_IDX_W'(MT_N - MT_M)
                                                        : ptr_reg + MT_IDX_W'(MT_M);

    assign twist_word = mt_mix(a_reg, b_reg, rdata_reg);
    assign draw       = mt_temper(mt_mix(seed_reg, e1_reg, v_last_reg));

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = v_sum;
        unique case (state_reg)
            S_SEED:
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = master_seed_reg;
            end
            S_INIT:  mem_we = 1'b1;
            S_TW:
            begin
                mem_we = 1'b1;
                mem_wa = ptr_reg;
                mem_wd = twist_word;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_RD1:   mem_ra = ptr_p1;
            S_RD2:   mem_ra = ptr_pm;
            default: mem_ra = ptr_reg;
        endcase
    end

    // Table storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[mem_ra];
    end

    // Sequencer, positions, configuration and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_SEED;
            node_count_reg     <= NODE_COUNT_RST;
            keep_threshold_reg <= KEEP_THRESHOLD_RST;
            master_seed_reg    <= MASTER_SEED_RST;
            row_reg            <= '0;
            col_reg            <= '0;
            ptr_reg            <= '0;
            idx_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_SEED:
                begin
                    prod_reg  <= mul_out;
                    idx_reg   <= MT_IDX_W'(1);
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    prod_reg <= mul_out;
                    if (idx_reg == MT_IDX_W'(MT_N - 1))
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + MT_IDX_W'(1);
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        bit_reg  <= in_data.cell_bit;
                        last_reg <= last_cell;
                        // advance positions
                        if (last_cell)
                        begin
                            row_reg <= '0;
                            col_reg <= '0;
                        end
                        else if (SIDE_W'(col_reg) + SIDE_W'(1) >= side)
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + POS_W'(1);
                        end
                        else
                            col_reg <= col_reg + POS_W'(1);

                        if (eligible)
                            state_reg <= S_RD0;
                        else
                        begin
                            out_reg       <= '{noisy_bit: in_data.cell_bit,
                                               was_flipped: 1'b0,
                                               matrix_end: last_cell};
                            out_valid_reg <= 1'b1;
                            state_reg     <= last_cell ? S_SEED : S_IDLE;
                        end
                    end
                end
                S_RD0: state_reg <= S_RD1;
                S_RD1:
                begin
                    a_reg     <= rdata_reg;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    b_reg     <= rdata_reg;
                    state_reg <= S_TW;
                end
                S_TW:
                begin
                    seed_reg  <= mt_temper(twist_word);
                    ptr_reg   <= ptr_p1;
                    state_reg <= S_FD0;
                end
                S_FD0:
                begin
                    prod_reg  <= mul_out;
                    idx_reg   <= MT_IDX_W'(1);
                    state_reg <= S_FD;
                end
                S_FD:
                begin
                    if (idx_reg == MT_IDX_W'(1))
                        e1_reg <= v_sum;
                    if (idx_reg == MT_IDX_W'(MT_M))
                    begin
                        v_last_reg <= v_sum;
                        state_reg  <= S_DRAW;
                    end
                    else
                    begin
                        prod_reg <= mul_out;
                        idx_reg  <= idx_reg + MT_IDX_W'(1);
                    end
                end
                S_DRAW:
                begin
                    flip_reg  <= draw > keep_threshold_reg;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= '{noisy_bit: bit_reg ^ flip_reg,
                                           was_flipped: flip_reg,
                                           matrix_end: last_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= last_reg ? S_SEED : S_IDLE;
                    end
                end
                default: state_reg <= S_SEED;
            endcase

            // Register writes; side or seed changes restart the matrix
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT:
                    begin
                        node_count_reg <= cfg_data[10:0];
                        row_reg        <= '0;
                        col_reg        <= '0;
                        state_reg      <= S_SEED;
                    end
                    CFG_KEEP_THRESHOLD: keep_threshold_reg <= cfg_data;
                    CFG_MASTER_SEED:
                    begin
                        master_seed_reg <= cfg_data;
                        row_reg         <= '0;
                        col_reg         <= '0;
                        state_reg       <= S_SEED;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    a_elig_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && eligible && !cfg_we |=> state_reg == S_RD0)
        else $error("eligible cell did not start the table read");
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg < MT_IDX_W'(MT_N))
        else $error("master pointer out of range");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        SIDE_W'(row_reg) < side && SIDE_W'(col_reg) < side)
        else $error("position outside the matrix");
    a_fd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FD |-> idx_reg <= MT_IDX_W'(MT_M) && idx_reg != '0)
        else $error("reseed step count out of range");
    a_inelig_direct: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !eligible |=> out_valid_reg && !out_reg.was_flipped)
        else $error("ineligible cell not passed straight through");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: self-checking bench for the randomized-response bit flipper
// Streams adjacency cells through the block under several matrix sizes, keep
// thresholds and seeds. A local Mersenne Twister model predicts every output
// word, and the monitor compares each one field by field, under random idling.
// -----------------------------------------------------------------------------
module tb_top;
    import rrbf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // beyond the register list
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 2500;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    randomized_response_bit_flip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    in_word_t  cell_q[$];
    out_word_t noisy_q[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_req;
    int        hold_cnt;
    int        errors;
    int        quiet_cycles;

    // Noise model state
    logic [31:0] mt_tab[MT_N];
    int          mt_ptr;
    int          row_pos;
    int          col_pos;
    logic [10:0] side_reg;
    logic [31:0] thr_reg;
    logic [31:0] seed_reg;

    function automatic logic [31:0] tempered(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9d2c5680);
        y = y ^ ((y << 15) & 32'hefc60000);
        return y ^ (y >> 18);
    endfunction

    function automatic logic [31:0] seed_step(input logic [31:0] p, input int i);
        return MT_MUL * (p ^ (p >> 30)) + i;
    endfunction

    function automatic logic [31:0] twisted(input logic [31:0] hi, input logic [31:0] lo,
                                            input logic [31:0] c);
        logic [31:0] y;
        y = (hi & MT_UPPER) | (lo & MT_LOWER);
        return c ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    endfunction

    function automatic void restart_matrix();
        row_pos = 0;
        col_pos = 0;
        mt_tab[0] = seed_reg;
        for (int i = 1; i < MT_N; i++)
            mt_tab[i] = seed_step(mt_tab[i-1], i);
        mt_ptr = MT_N;
    endfunction

    function automatic logic [31:0] next_master_word();
        if (mt_ptr >= MT_N)
        begin
            for (int k = 0; k < MT_N; k++)
                mt_tab[k] = twisted(mt_tab[k], mt_tab[(k+1) % MT_N], mt_tab[(k+MT_M) % MT_N]);
            mt_ptr = 0;
        end
        mt_ptr++;
        return tempered(mt_tab[mt_ptr-1]);
    endfunction

    // First output of a generator freshly seeded with s
    function automatic logic [31:0] reseeded_draw(input logic [31:0] s);
        logic [31:0] v;
        logic [31:0] e1;
        v = s;
        e1 = '0;
        for (int i = 1; i <= MT_M; i++)
        begin
            v = seed_step(v, i);
            if (i == 1)
                e1 = v;
        end
        return tempered(twisted(s, e1, v));
    endfunction

    function automatic out_word_t noisy_cell(input in_word_t c);
        out_word_t r;
        int n;
        logic flip;
        n = (side_reg < 2) ? 2 : (side_reg > MAX_NODES) ? MAX_NODES : int'(side_reg);
        if (row_pos >= n || col_pos >= n)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        flip = 1'b0;
        if (!c.row_exempt && row_pos != col_pos)
            flip = reseeded_draw(next_master_word()) > thr_reg;
        r.noisy_bit   = c.cell_bit ^ flip;
        r.was_flipped = flip;
        r.matrix_end  = (row_pos == n-1) && (col_pos == n-1);
        if (r.matrix_end)
            restart_matrix();
        else if (col_pos + 1 >= n)
        begin
            col_pos = 0;
            row_pos++;
        end
        else
            col_pos++;
        return r;
    endfunction

    // Driver: next cell word from the queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (cell_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= cell_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (hold_req && hold_cnt < HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predict on input words, check output words, watchdog
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                noisy_q.push_back(noisy_cell(in_data));
            if (out_valid && !out_stall)
            begin
                if (noisy_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word %b", $time, out_data);
                end
                else
                begin
                    want = noisy_q.pop_front();
                    if (out_data.noisy_bit !== want.noisy_bit)
                    begin
                        errors++;
                        $display("%0t: noisy_bit expected %b got %b", $time,
                                 want.noisy_bit, out_data.noisy_bit);
                    end
                    if (out_data.was_flipped !== want.was_flipped)
                    begin
                        errors++;
                        $display("%0t: was_flipped expected %b got %b", $time,
                                 want.was_flipped, out_data.was_flipped);
                    end
                    if (out_data.matrix_end !== want.matrix_end)
                    begin
                        errors++;
                        $display("%0t: matrix_end expected %b got %b", $time,
                                 want.matrix_end, out_data.matrix_end);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[randomized_response_bit_flip] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_NODE_COUNT)
        begin
            side_reg = val[10:0];
            restart_matrix();
        end
        else if (idx == CFG_KEEP_THRESHOLD)
            thr_reg = val;
        else if (idx == CFG_MASTER_SEED)
        begin
            seed_reg = val;
            restart_matrix();
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_cell(input logic b, input logic ex);
        in_word_t c;
        c.cell_bit   = b;
        c.row_exempt = ex;
        cell_q.push_back(c);
    endtask

    // Wait until the block has gone quiet
    task automatic drain();
        while (cell_q.size() > 0 || noisy_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        @(negedge clk);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    // Mostly whole rows with one exemption flag, some scattered noise
    task automatic random_cells(input int count, input int n);
        logic ex;
        ex = 1'b0;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            if (i % n == 0)
                ex = ($urandom_range(99) < 20);
            if ($urandom_range(99) < 85)
                add_cell(1'($urandom_range(1)), ex);
            else
                add_cell(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int n;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        side_reg = NODE_COUNT_RST;
        thr_reg = KEEP_THRESHOLD_RST;
        seed_reg = MASTER_SEED_RST;
        restart_matrix();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, one 2x2 matrix
        @(negedge clk);
        add_cell(1'b0, 1'b0);
        add_cell(1'b1, 1'b0);
        add_cell(1'b1, 1'b0);
        add_cell(1'b0, 1'b0);
        drain();

        // 3x3 matrix, middle row exempt, every nonzero draw flips
        write_reg(CFG_NODE_COUNT, 32'd3);
        write_reg(CFG_KEEP_THRESHOLD, 32'd0);
        write_reg(CFG_MASTER_SEED, 32'hffffffff);
        @(negedge clk);
        for (int i = 0; i < 9; i++)
            add_cell(i[0], i / 3 == 1);
        drain();

        // Nothing ever flips; side below range acts as two; spare index ignored
        write_reg(CFG_KEEP_THRESHOLD, 32'hffffffff);
        write_reg(CFG_NODE_COUNT, 32'd0);
        write_reg(CFG_MASTER_SEED, 32'd0);
        write_reg(CFG_SPARE, 32'hdeadbeef);
        @(negedge clk);
        for (int i = 0; i < 5; i++)
            add_cell(~i[0], 1'b0);
        drain();

        // Side above range acts as the maximum
        write_reg(CFG_NODE_COUNT, 32'h7ff);
        write_reg(CFG_KEEP_THRESHOLD, 32'h7fffffff);
        @(negedge clk);
        add_cell(1'b1, 1'b1);
        add_cell(1'b0, 1'b0);
        add_cell(1'b1, 1'b0);
        drain();

        // Random phases over sizes, thresholds, seeds and idling
        for (int ph = 0; ph < 9; ph++)
        begin
            n = (ph == 4) ? MAX_NODES : $urandom_range(2, 6);
            write_reg(CFG_NODE_COUNT, n);
            write_reg(CFG_KEEP_THRESHOLD, (ph % 3 == 0) ? $urandom_range(32'h3fffffff) :
                                          $urandom());
            write_reg(CFG_MASTER_SEED, $urandom());
            set_idling(ph % 4);
            if (ph == 2)
            begin
                @(negedge clk);
                hold_req = 1'b1;
            end
            random_cells((ph == 4) ? 12 : 25, n);
            // sender waits until every word is back, then carries on
            drain();
            random_cells((ph == 4) ? 8 : 25, n);
            drain();
            if (ph == 5)
            begin
                // threshold change mid-matrix, no restart
                write_reg(CFG_KEEP_THRESHOLD, 32'd1);
                random_cells(20, n);
                drain();
            end
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[randomized_response_bit_flip] OK");
        else
            $display("[randomized_response_bit_flip] ERROR");
        $finish;
    end

endmodule
